### rtl/assert_macros.svh
// assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vector3_normalize assertion failed");
`define VN_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("vector3_normalize assertion failed");
`else
`define VN_ASSERT(lbl, clk, rst, prop)
`define VN_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

### rtl/vn_pkg.sv
package vn_pkg;
   localparam int CompW = 32;
   localparam int SqW = 64;
   localparam int SumW = 64;
   localparam int RemW = 128;
   localparam int QsW = 96;
   localparam int QW = 31;
   localparam int FracBits = 30;
   localparam int NumBits = 31;
   localparam int BitIdxW = 5;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [QsW-1:0]  qs;
      logic [QW-1:0]   q;
   } vn_lane_type;

   typedef struct packed {
      logic               valid;
      logic [SumW-1:0]    sum;
      logic [2:0]         neg;
      vn_lane_type [2:0]  lane;
   } vn_stage_type;
endpackage

### rtl/vn_front.sv
module vn_front import vn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [3*CompW-1:0] in_data,
   output vn_stage_type      stage_out
);
   logic [2:0]            neg_in, neg_ff;
   logic [CompW-1:0]      mag [3];
   logic [SqW-1:0]        sq_in [3];
   logic [SqW-1:0]        sq_ff [3];
   logic                  valid_ff;
   vn_stage_type          stage_in, stage_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = in_data[i*CompW + CompW-1];
         mag[i] = neg_in[i] ? (~in_data[i*CompW +: CompW] + 1'b1) : in_data[i*CompW +: CompW];
         sq_in[i] = SqW'(mag[i]) * SqW'(mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= neg_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   always_comb begin
      stage_in.valid = valid_ff;
      stage_in.neg = neg_ff;
      stage_in.sum = sq_ff[0] + sq_ff[1] + sq_ff[2];
      for (int i = 0; i < 3; i++) begin
         stage_in.lane[i].rem = {(RemW-SqW-2*FracBits)'(0), sq_ff[i], (2*FracBits)'(0)};
         stage_in.lane[i].qs = '0;
         stage_in.lane[i].q = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.sum <= stage_in.sum;
         stage_ff.neg <= stage_in.neg;
         stage_ff.lane <= stage_in.lane;
      end
   end

   assign stage_out = stage_ff;
endmodule

### rtl/vn_cell.sv
module vn_cell import vn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [BitIdxW-1:0] bit_idx,
   input  vn_stage_type       stage_in,
   output vn_stage_type       stage_out
);
   vn_stage_type        stage_in_w, stage_ff;
   logic [RemW-1:0]     delta [3];
   logic [BitIdxW:0]    sh1, sh2;
   logic                take [3];

   always_comb begin
      sh1 = {1'b0, bit_idx} + 1'b1;
      sh2 = {bit_idx, 1'b0};
      stage_in_w = stage_in;
      for (int i = 0; i < 3; i++) begin
         delta[i] = ({(RemW-QsW)'(0), stage_in.lane[i].qs} << sh1)
                  + ({(RemW-SumW)'(0), stage_in.sum} << sh2);
         take[i] = !stage_in.lane[i].q[QW-1] && (stage_in.lane[i].rem >= delta[i]);
         if (take[i]) begin
            stage_in_w.lane[i].rem = stage_in.lane[i].rem - delta[i];
            stage_in_w.lane[i].qs = stage_in.lane[i].qs
                                  + (QsW'(stage_in.sum) << bit_idx);
            stage_in_w.lane[i].q = stage_in.lane[i].q | (QW'(1) << bit_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (en) begin
         stage_ff.sum <= stage_in_w.sum;
         stage_ff.neg <= stage_in_w.neg;
         stage_ff.lane <= stage_in_w.lane;
      end
   end

   assign stage_out = stage_ff;
endmodule

### rtl/vector3_normalize.sv
// channel | direction | tdata (low bit up)            | tuser
// req     | in        | vec_x, vec_y, vec_z (96 bits) | -
// rsp     | out       | norm_x, norm_y, norm_z        | zero_length
// One beat per cycle while the output is not stalled: a front that registers
// the squares and then their sum, one cell per quotient bit (31 cells), one output register.
// The whole pipeline advances when the output register is empty or taken.
// Synchronous reset clears the valid bits only.
module vector3_normalize import vn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [3*CompW-1:0] req_tdata,   // vec_x, vec_y, vec_z
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [3*CompW-1:0] rsp_tdata,   // norm_x, norm_y, norm_z
   output logic               rsp_tuser    // zero_length
);
`include "assert_macros.svh"
   logic                 en;
   vn_stage_type         chain [NumBits+1];
   logic                 rsp_valid_ff;
   logic [3*CompW-1:0]   rsp_data_ff, rsp_data_in;
   logic                 rsp_zero_ff, rsp_zero_in;
   logic [CompW-1:0]     qext [3];

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   vn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .stage_out (chain[0])
   );

   for (genvar g = 0; g < NumBits; g++) begin : g_cell
      vn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .bit_idx   (BitIdxW'(NumBits-1-g)),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   always_comb begin
      rsp_zero_in = (chain[NumBits].sum == '0);
      for (int i = 0; i < 3; i++) begin
         qext[i] = {(CompW-QW)'(0), chain[NumBits].lane[i].q};
         if (rsp_zero_in) begin
            rsp_data_in[i*CompW +: CompW] = '0;
         end else if (chain[NumBits].neg[i]) begin
            rsp_data_in[i*CompW +: CompW] = ~qext[i] + 1'b1;
         end else begin
            rsp_data_in[i*CompW +: CompW] = qext[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain[NumBits].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_zero_ff <= rsp_zero_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_zero_ff;

   `VN_ASSERT(a_zero_clears, clock, reset, !(rsp_tvalid && rsp_tuser) || (rsp_tdata == '0))
   `VN_ASSERT(a_x_range, clock, reset, !rsp_tvalid || (!rsp_tdata[31] && rsp_tdata[31:0] <= 32'h40000000) || (rsp_tdata[31] && rsp_tdata[31:0] >= 32'hC0000000))
   `VN_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(chain[NumBits]))
endmodule
